@@ rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON string unescape package
// Phase and status codes and the result record shared by the unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_DONE    = 3'd1,
        ST_NOQUOTE = 3'd2,
        ST_BADESC  = 3'd3,
        ST_BADHEX  = 3'd4,
        ST_SURR    = 3'd5,
        ST_CTRL    = 3'd6,
        ST_EARLY   = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       last_of_run;
    } t_result;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned MAX_RESULTS = 3;

endpackage

`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Decodes one JSON string byte per beat into UTF-8 bytes and status results.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  ------------------------------------
//  input    in         i_valid / o_stall       i_in_byte, i_end_of_input
//  output   out        o_valid / i_stall       o_out_byte, o_status, o_last_of_run
//
//  An accepted byte is held in an input register and decoded once the queue has
//  room, when its zero to three results are written into a four-entry result
//  queue; the oldest queued result is offered at the queue head.
//  Sustained rate is one byte per cycle while the queue has room; the queue admits a decode only when at
//  most one entry remains after this cycle's drain, so a u escape briefly slows
//  intake while its up to three bytes drain.
//  Reset is synchronous and active low and empties the queue and returns to
//  idle; the input stalls whenever the decoded byte cannot yet be queued.
//
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_last_of_run
);

    // Input register
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    // Decoder state
    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_accum, n_code_accum;

    // Result queue
    t_result     r_q [QUEUE_DEPTH];
    logic [1:0]  r_head, n_head;
    logic [2:0]  r_count, n_count;

    logic        w_accept, w_pop, w_proc;
    logic [2:0]  w_after_pop;
    logic [1:0]  w_tail;
    logic [1:0]  w_res_n;
    t_result     w_res [MAX_RESULTS];
    logic        w_hex_ok;
    logic [3:0]  w_hex_d;
    logic [15:0] w_cp;

    function automatic t_result mk(input logic [7:0] b, input t_status s, input logic l);
        t_result r;
        r.out_byte    = b;
        r.status      = s;
        r.last_of_run = l;
        return r;
    endfunction

    assign w_pop       = o_valid && !i_stall;
    assign w_after_pop = r_count - {2'b00, w_pop};
    assign w_proc      = r_in_valid && (w_after_pop <= 3'd1);
    assign o_stall     = r_in_valid && !w_proc;
    assign w_accept    = i_valid && !o_stall;
    assign w_tail      = r_head + r_count[1:0];

    assign o_valid       = (r_count != 3'd0);
    assign o_out_byte    = r_q[r_head].out_byte;
    assign o_status      = r_q[r_head].status;
    assign o_last_of_run = r_q[r_head].last_of_run;

    always_comb begin
        w_hex_ok = 1'b1;
        w_hex_d  = 4'd0;
        if (r_in_byte >= 8'h30 && r_in_byte <= 8'h39) begin
            w_hex_d = r_in_byte[3:0];
        end else if ((r_in_byte >= 8'h61 && r_in_byte <= 8'h66) ||
                     (r_in_byte >= 8'h41 && r_in_byte <= 8'h46)) begin
            w_hex_d = r_in_byte[3:0] + 4'd9;
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    assign w_cp = {r_code_accum[11:0], w_hex_d};

    // Decode the held byte into next state and up to three results
    always_comb begin
        n_phase      = r_phase;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        w_res_n      = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            w_res[k] = mk(8'h00, ST_DATA, 1'b0);
        end

        unique case (r_phase)
            PH_STR: begin
                if (r_in_end) begin
                    n_phase = PH_IDLE; n_hex_count = 2'd0; n_code_accum = 16'd0;
                    w_res[0] = mk(8'h00, ST_EARLY, 1'b1); w_res_n = 2'd1;
                end else if (r_in_byte == 8'h22) begin
                    n_phase = PH_IDLE; n_hex_count = 2'd0; n_code_accum = 16'd0;
                    w_res[0] = mk(8'h00, ST_DONE, 1'b1); w_res_n = 2'd1;
                end else if (r_in_byte == 8'h5C) begin
                    n_phase = PH_ESC;
                end else if (r_in_byte < 8'h20) begin
                    n_phase = PH_IDLE; n_hex_count = 2'd0; n_code_accum = 16'd0;
                    w_res[0] = mk(8'h00, ST_CTRL, 1'b1); w_res_n = 2'd1;
                end else begin
                    w_res[0] = mk(r_in_byte, ST_DATA, 1'b1); w_res_n = 2'd1;
                end
            end
            PH_ESC: begin
                if (r_in_end) begin
                    n_phase = PH_IDLE; n_hex_count = 2'd0; n_code_accum = 16'd0;
                    w_res[0] = mk(8'h00, ST_EARLY, 1'b1); w_res_n = 2'd1;
                end else begin
                    n_phase  = PH_STR;
                    w_res_n  = 2'd1;
                    unique case (r_in_byte)
                        8'h22, 8'h5C, 8'h2F: w_res[0] = mk(r_in_byte, ST_DATA, 1'b1);
                        8'h62: w_res[0] = mk(8'h08, ST_DATA, 1'b1);
                        8'h66: w_res[0] = mk(8'h0C, ST_DATA, 1'b1);
                        8'h6E: w_res[0] = mk(8'h0A, ST_DATA, 1'b1);
                        8'h72: w_res[0] = mk(8'h0D, ST_DATA, 1'b1);
                        8'h74: w_res[0] = mk(8'h09, ST_DATA, 1'b1);
                        8'h75: begin
                            n_phase = PH_HEX; n_hex_count = 2'd0; n_code_accum = 16'd0;
                            w_res_n = 2'd0;
                        end
                        default: begin
                            n_phase = PH_IDLE; n_hex_count = 2'd0; n_code_accum = 16'd0;
                            w_res[0] = mk(8'h00, ST_BADESC, 1'b1);
                        end
                    endcase
                end
            end
            PH_HEX: begin
                if (r_in_end || !w_hex_ok) begin
                    n_phase = PH_IDLE; n_hex_count = 2'd0; n_code_accum = 16'd0;
                    w_res[0] = mk(8'h00, r_in_end ? ST_EARLY : ST_BADHEX, 1'b1);
                    w_res_n  = 2'd1;
                end else if (r_hex_count != 2'd3) begin
                    n_hex_count  = r_hex_count + 2'd1;
                    n_code_accum = w_cp;
                end else begin
                    n_hex_count  = 2'd0;
                    n_code_accum = 16'd0;
                    if (w_cp >= 16'hD800 && w_cp <= 16'hDFFF) begin
                        n_phase  = PH_IDLE;
                        w_res[0] = mk(8'h00, ST_SURR, 1'b1); w_res_n = 2'd1;
                    end else begin
                        n_phase = PH_STR;
                        if (w_cp <= 16'h007F) begin
                            w_res[0] = mk(w_cp[7:0], ST_DATA, 1'b1);
                            w_res_n  = 2'd1;
                        end else if (w_cp <= 16'h07FF) begin
                            w_res[0] = mk({3'b110, w_cp[10:6]}, ST_DATA, 1'b0);
                            w_res[1] = mk({2'b10, w_cp[5:0]}, ST_DATA, 1'b1);
                            w_res_n  = 2'd2;
                        end else begin
                            w_res[0] = mk({4'b1110, w_cp[15:12]}, ST_DATA, 1'b0);
                            w_res[1] = mk({2'b10, w_cp[11:6]}, ST_DATA, 1'b0);
                            w_res[2] = mk({2'b10, w_cp[5:0]}, ST_DATA, 1'b1);
                            w_res_n  = 2'd3;
                        end
                    end
                end
            end
            default: begin
                // Idle: whitespace is skipped, a quote opens the string, else a no-quote result
                n_phase = PH_IDLE;
                if (!r_in_end && r_in_byte == 8'h22) begin
                    n_phase = PH_STR;
                end else if (r_in_end || !(r_in_byte == 8'h20 || r_in_byte == 8'h0A ||
                                           r_in_byte == 8'h0D || r_in_byte == 8'h09)) begin
                    n_hex_count = 2'd0; n_code_accum = 16'd0;
                    w_res[0] = mk(8'h00, ST_NOQUOTE, 1'b1); w_res_n = 2'd1;
                end
            end
        endcase
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_proc) begin
            n_in_valid = 1'b0;
        end
        n_head  = r_head + {1'b0, w_pop};
        n_count = w_after_pop + (w_proc ? {1'b0, w_res_n} : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_IDLE;
            r_hex_count  <= 2'd0;
            r_code_accum <= 16'd0;
            r_head       <= 2'd0;
            r_count      <= 3'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_head     <= n_head;
            r_count    <= n_count;
            if (w_proc) begin
                r_phase      <= n_phase;
                r_hex_count  <= n_hex_count;
                r_code_accum <= n_code_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_end_of_input;
        end
        if (w_proc) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (2'(k) < w_res_n) begin
                    r_q[w_tail + 2'(k)] <= w_res[k];
                end
            end
        end
    end

    // The queue never holds more entries than it has
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overfilled");

    // Hex gathering state is clear outside a u escape
    a_hex_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEX) |-> (r_hex_count == 2'd0 && r_code_accum == 16'd0))
        else $error("hex state left over outside a u escape");

    // A decode only happens when the queue can take every result it makes
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> (r_count <= 3'd4) && ($past(w_after_pop) + 3'd3 <= 3'd4))
        else $error("decode admitted without queue room");

endmodule

`default_nettype wire
